FILE: src/mxr_pkg.sv
// Shared types, constants and routing function of the XY mesh router.
package mxr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int FIFO_DEPTH_DEF  = 5;
    localparam int LOCAL_DEPTH_DEF = 64;
    localparam int COUNT_BITS_DEF  = 10;

    // Coordinates are compared within this many bits of each half.
    localparam int              COORD_BITS = 8;
    localparam logic [15:0]     COORD_MASK = 16'((17'd1 << COORD_BITS) - 17'd1);

    // Link ports and requesters.
    localparam int NUM_PORTS = 4;
    localparam int NUM_REQ   = 5;
    localparam int REQ_LOCAL = 4;

    // Configuration register indexes.
    localparam logic CFG_OWN_X = 1'b0;
    localparam logic CFG_OWN_Y = 1'b1;

    // Input word kinds carried on tuser.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Output choices of the router; eject means delivery to this node.
    typedef enum logic [2:0] {
        PORT_LEFT,
        PORT_RIGHT,
        PORT_UP,
        PORT_DOWN,
        PORT_EJECT
    } t_port;

    // One queue head offered to the arbiter.
    typedef struct packed {
        logic        vld;
        logic [15:0] dst;
    } t_head;

    // Arbitration outcome of one tick.
    typedef struct packed {
        logic [NUM_REQ-1:0]       grant;
        logic [NUM_REQ-1:0]       taken;
        logic [NUM_REQ-1:0][15:0] port_dst;
    } t_arb_res;

    // Input word, lowest field last (packed structs fill from the top).
    typedef struct packed {
        logic [5:0]  pad;
        logic [9:0]  local_count;
        logic [15:0] local_dst;
        logic [3:0]  credit_return;
        logic [15:0] arrive_dst_down;
        logic [15:0] arrive_dst_up;
        logic [15:0] arrive_dst_right;
        logic [15:0] arrive_dst_left;
        logic [3:0]  link_valid;
    } t_in_word;

    // Result word, lowest field last.
    typedef struct packed {
        logic [2:0]  pad;
        logic        overflow;
        logic        load_rejected;
        logic        pending;
        logic        busy_res;
        logic [3:0]  credit_release;
        logic [15:0] eject_dst;
        logic        eject_valid;
        logic [15:0] send_dst_down;
        logic [15:0] send_dst_up;
        logic [15:0] send_dst_right;
        logic [15:0] send_dst_left;
        logic [3:0]  send_valid;
    } t_out_word;

    // X first, then Y, otherwise eject.
    function automatic t_port route_port(input logic [15:0] dst,
                                         input logic [7:0]  own_x,
                                         input logic [7:0]  own_y);
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] ox;
        logic [15:0] oy;
        t_port       p;
        dx = dst & COORD_MASK;
        dy = (dst >> COORD_BITS) & COORD_MASK;
        ox = {8'h00, own_x} & COORD_MASK;
        oy = {8'h00, own_y} & COORD_MASK;
        if (dx > ox) begin
            p = PORT_RIGHT;
        end else if (dx < ox) begin
            p = PORT_LEFT;
        end else if (dy > oy) begin
            p = PORT_UP;
        end else if (dy < oy) begin
            p = PORT_DOWN;
        end else begin
            p = PORT_EJECT;
        end
        return p;
    endfunction

endpackage

FILE: src/mesh_xy_credit_router.sv
// Top level of the XY dimension-order mesh router with credit flow control.
//
// One input word is either a traffic tick (tuser = 0) or a local load (tuser = 1).
// A tick carries the arrivals on the four links and the credits returned by the
// neighbours; the router arbitrates its four link FIFOs and the local queue in
// fixed priority (left, right, up, down, local), routes X first then Y, and
// returns one result word with the sends, the ejection and the released credits.
// A load appends an entry to the local queue and returns a word that only flags
// a rejection when the queue was full.
// Each word enters an input register; its result moves on into the output
// register once the result slot is free, and is taken from there.
// A new word is accepted every cycle while results are taken; the rate is set
// by the update of FIFOs, credits and local queue head that feeds the next word.
// When the receiver stalls, the result is held and the input register fills;
// s_axis_tready then falls until the result is taken.
// The configuration port (own_x at index 0, own_y at index 1) is always ready.
// The user must see that it is written while no word is in flight; it is not checked.
// Reset clears all FIFOs and the local queue, sets every output credit to the
// FIFO depth and both coordinates to zero.
module mesh_xy_credit_router #(
    parameter int FIFO_DEPTH  = mxr_pkg::FIFO_DEPTH_DEF,
    parameter int LOCAL_DEPTH = mxr_pkg::LOCAL_DEPTH_DEF,
    parameter int COUNT_BITS  = mxr_pkg::COUNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata from bit 0: link_valid, arrive_dst_left, arrive_dst_right,
    // arrive_dst_up, arrive_dst_down, credit_return, local_dst, local_count, zeros
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    // tuser: kind
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: send_valid, send_dst_left, send_dst_right, send_dst_up,
    // send_dst_down, eject_valid, eject_dst, credit_release, busy_res, pending,
    // load_rejected, overflow, zeros
    output logic [95:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    logic                                r_in_vld;
    logic                                r_in_kind;
    mxr_pkg::t_in_word                   r_in;
    logic                                r_out_vld;
    mxr_pkg::t_out_word                  r_out;
    mxr_pkg::t_out_word                  n_out;
    logic [7:0]                          r_own_x;
    logic [7:0]                          r_own_y;
    logic                                advance;
    logic                                tick;
    logic                                load;
    mxr_pkg::t_head [mxr_pkg::NUM_REQ-1:0] heads;
    mxr_pkg::t_arb_res                   arb;
    logic [mxr_pkg::NUM_PORTS-1:0]       fifo_ovf;
    logic [mxr_pkg::NUM_PORTS-1:0][15:0] arrive_dst;
    logic                                lq_full;

    // Handshake: the word in the input register moves on when the result slot frees.
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign o_cfg_ready   = 1'b1;

    assign tick = advance && (r_in_kind == mxr_pkg::KIND_TICK);
    assign load = advance && (r_in_kind == mxr_pkg::KIND_LOAD);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in      <= s_axis_tdata;
            r_in_kind <= s_axis_tuser;
        end
    end

    // Coordinate registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x <= '0;
            r_own_y <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mxr_pkg::CFG_OWN_X: r_own_x <= i_cfg_data;
                mxr_pkg::CFG_OWN_Y: r_own_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign arrive_dst[0] = r_in.arrive_dst_left;
    assign arrive_dst[1] = r_in.arrive_dst_right;
    assign arrive_dst[2] = r_in.arrive_dst_up;
    assign arrive_dst[3] = r_in.arrive_dst_down;

    // Link input FIFOs.
    for (genvar g = 0; g < mxr_pkg::NUM_PORTS; g++) begin : g_link
        mxr_link_fifo #(
            .DEPTH (FIFO_DEPTH)
        ) u_fifo (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pop      (arb.grant[g]),
            .i_push     (tick && r_in.link_valid[g]),
            .i_push_dst (arrive_dst[g]),
            .o_head     (heads[g]),
            .o_overflow (fifo_ovf[g])
        );
    end

    // Local send queue.
    mxr_local_queue #(
        .LOCAL_DEPTH (LOCAL_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_local (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_load_dst   (r_in.local_dst),
        .i_load_count (COUNT_BITS'(r_in.local_count)),
        .i_grant      (arb.grant[mxr_pkg::REQ_LOCAL]),
        .o_head       (heads[mxr_pkg::REQ_LOCAL]),
        .o_full       (lq_full)
    );

    // Arbitration and credits.
    mxr_arbiter #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_arb (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick          (tick),
        .i_own_x         (r_own_x),
        .i_own_y         (r_own_y),
        .i_heads         (heads),
        .i_credit_return (r_in.credit_return),
        .o_res           (arb)
    );

    // Result word.
    always_comb begin
        logic any_head;
        any_head = 1'b0;
        for (int r = 0; r < mxr_pkg::NUM_REQ; r++) begin
            any_head = any_head | heads[r].vld;
        end
        n_out = '0;
        if (r_in_kind == mxr_pkg::KIND_LOAD) begin
            n_out.load_rejected = lq_full;
        end else begin
            n_out.send_valid     = arb.taken[mxr_pkg::NUM_PORTS-1:0];
            n_out.send_dst_left  = arb.port_dst[mxr_pkg::PORT_LEFT];
            n_out.send_dst_right = arb.port_dst[mxr_pkg::PORT_RIGHT];
            n_out.send_dst_up    = arb.port_dst[mxr_pkg::PORT_UP];
            n_out.send_dst_down  = arb.port_dst[mxr_pkg::PORT_DOWN];
            n_out.eject_valid    = arb.taken[mxr_pkg::PORT_EJECT];
            n_out.eject_dst      = arb.port_dst[mxr_pkg::PORT_EJECT];
            n_out.credit_release = arb.grant[mxr_pkg::NUM_PORTS-1:0];
            n_out.busy_res       = |arb.grant;
            n_out.pending        = any_head;
            n_out.overflow       = |fifo_ovf;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    // A rejected load word carries no traffic.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.load_rejected) |->
            (r_out.send_valid == '0 && !r_out.eject_valid && !r_out.busy_res))
        else $error("load result shows traffic");

    // Something moved exactly when a port or the ejection was used.
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.busy_res == ((r_out.send_valid != '0) || r_out.eject_valid)))
        else $error("busy flag disagrees with sends");

    // A released credit means a link queue was waiting at arbitration.
    a_release_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.credit_release != '0)) |-> r_out.pending)
        else $error("credit released with nothing pending");
`endif

endmodule

FILE: src/mxr_link_fifo.sv
// Input FIFO of one link with pop-before-push and overflow detection.
module mxr_link_fifo #(
    parameter int DEPTH = mxr_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [15:0]   i_push_dst,
    output mxr_pkg::t_head o_head,
    output logic          o_overflow
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    logic [15:0]       r_store [DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_head;
    logic [FILL_W-1:0] n_fill;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic              push_ok;

    // Head word is read straight from its slot.
    assign o_head.vld = (r_fill != '0);
    assign o_head.dst = r_store[r_head];

    // A pop in the same tick frees a slot for the arrival.
    assign push_ok    = i_push && ((r_fill != FILL_W'(DEPTH)) || i_pop);
    assign o_overflow = i_push && !push_ok;

    // Tail slot, head plus fill wrapped once.
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
    assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);

    // Pointer and fill update.
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_pop) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        n_fill = r_fill - FILL_W'(i_pop) + FILL_W'(push_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // Storage of arriving words.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_store[tail] <= i_push_dst;
        end
    end

`ifndef SYNTH
    // The fill level never passes the depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("link FIFO fill above depth");
`endif

endmodule

FILE: src/mxr_local_queue.sv
// Local send queue: ring memory with the head entry held in registers.
module mxr_local_queue #(
    parameter int LOCAL_DEPTH = mxr_pkg::LOCAL_DEPTH_DEF,
    parameter int COUNT_BITS  = mxr_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [15:0]           i_load_dst,
    input  logic [COUNT_BITS-1:0] i_load_count,
    input  logic                  i_grant,
    output mxr_pkg::t_head        o_head,
    output logic                  o_full
);

    localparam int PTR_W   = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
    localparam int FILL_W  = $clog2(LOCAL_DEPTH + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int ENTRY_W = 16 + COUNT_BITS;

    logic [ENTRY_W-1:0]    mem [LOCAL_DEPTH];
    logic [PTR_W-1:0]      r_head;
    logic [FILL_W-1:0]     r_fill;
    logic [15:0]           r_hd_dst;
    logic [COUNT_BITS-1:0] r_hd_cnt;
    logic [ENTRY_W-1:0]    r_rd_data;
    logic                  r_byp;
    logic [ENTRY_W-1:0]    r_byp_data;
    logic [PTR_W-1:0]      n_head;
    logic [FILL_W-1:0]     n_fill;
    logic [15:0]           n_hd_dst;
    logic [COUNT_BITS-1:0] n_hd_cnt;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      wr_addr;
    logic [PTR_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ENTRY_W-1:0]    next_entry;
    logic                  wr_en;
    logic                  pop;

    assign o_head.vld = (r_fill != '0);
    assign o_head.dst = r_hd_dst;
    assign o_full     = (r_fill == FILL_W'(LOCAL_DEPTH));

    // Write slot behind the last entry.
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
    assign wr_addr  = (tail_sum >= SUM_W'(LOCAL_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(LOCAL_DEPTH)) : PTR_W'(tail_sum);
    assign wr_en    = i_load && !o_full;
    assign wr_data  = {i_load_dst, i_load_count};

    // Entry after the head, with a write of the previous cycle forwarded.
    assign next_entry = r_byp ? r_byp_data : r_rd_data;

    // An entry leaves once its last copy is sent; a count of zero sends one.
    assign pop = i_grant && (r_hd_cnt <= COUNT_BITS'(1));

    // Head, fill and head entry update.
    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        n_hd_dst = r_hd_dst;
        n_hd_cnt = r_hd_cnt;
        if (wr_en) begin
            n_fill = r_fill + 1'b1;
            if (r_fill == '0) begin
                n_hd_dst = i_load_dst;
                n_hd_cnt = i_load_count;
            end
        end else if (pop) begin
            n_head   = (r_head == PTR_W'(LOCAL_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_fill   = r_fill - 1'b1;
            n_hd_dst = next_entry[ENTRY_W-1:COUNT_BITS];
            n_hd_cnt = next_entry[COUNT_BITS-1:0];
        end else if (i_grant) begin
            n_hd_cnt = r_hd_cnt - 1'b1;
        end
    end

    // Prefetch the slot after the coming head.
    assign rd_addr = (n_head == PTR_W'(LOCAL_DEPTH - 1)) ? '0 : n_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            r_byp  <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Head entry payload.
    always_ff @(posedge i_clk) begin
        r_hd_dst   <= n_hd_dst;
        r_hd_cnt   <= n_hd_cnt;
        r_byp_data <= wr_data;
    end

    // Queue memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
    end

`ifndef SYNTH
    // A grant is only ever given to a queue that holds an entry.
    a_grant_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grant |-> (r_fill != '0))
        else $error("local queue granted while empty");
`endif

endmodule

FILE: src/mxr_arbiter.sv
// Fixed-priority XY arbiter with per-port output credit counters.
module mxr_arbiter #(
    parameter int FIFO_DEPTH = mxr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_tick,
    input  logic [7:0]                              i_own_x,
    input  logic [7:0]                              i_own_y,
    input  mxr_pkg::t_head [mxr_pkg::NUM_REQ-1:0]   i_heads,
    input  logic [mxr_pkg::NUM_PORTS-1:0]           i_credit_return,
    output mxr_pkg::t_arb_res                       o_res
);

    localparam int CRED_W = $clog2(FIFO_DEPTH + 1);

    logic [CRED_W-1:0]            r_credit [mxr_pkg::NUM_PORTS];
    logic [CRED_W-1:0]            n_credit [mxr_pkg::NUM_PORTS];
    logic [mxr_pkg::NUM_REQ-1:0]  cred_ok;

    // A port may be granted only while it holds a credit; ejection always may.
    always_comb begin
        for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
            cred_ok[i] = (r_credit[i] != '0);
        end
        cred_ok[mxr_pkg::PORT_EJECT] = 1'b1;
    end

    // Walk the requesters in priority order, each takes a free output.
    always_comb begin
        mxr_pkg::t_port p;
        logic           ok;
        o_res = '0;
        for (int r = 0; r < mxr_pkg::NUM_REQ; r++) begin
            p  = mxr_pkg::route_port(i_heads[r].dst, i_own_x, i_own_y);
            ok = i_tick && i_heads[r].vld && !o_res.taken[p] && cred_ok[p];
            if (ok) begin
                o_res.grant[r]    = 1'b1;
                o_res.taken[p]    = 1'b1;
                o_res.port_dst[p] = i_heads[r].dst;
            end
        end
    end

    // Spend a credit per send, then take back a returned one up to the depth.
    always_comb begin
        logic [CRED_W-1:0] c;
        for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
            c = r_credit[i] - CRED_W'(o_res.taken[i]);
            if (i_tick && i_credit_return[i] && (c < CRED_W'(FIFO_DEPTH))) begin
                c = c + 1'b1;
            end
            n_credit[i] = c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
                r_credit[i] <= CRED_W'(FIFO_DEPTH);
            end
        end else begin
            for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
                r_credit[i] <= n_credit[i];
            end
        end
    end

`ifndef SYNTH
    // A send on a port never leaves its credit count wrapped around.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_credit[0] <= CRED_W'(FIFO_DEPTH)) && (r_credit[1] <= CRED_W'(FIFO_DEPTH)) &&
        (r_credit[2] <= CRED_W'(FIFO_DEPTH)) && (r_credit[3] <= CRED_W'(FIFO_DEPTH)))
        else $error("output credit above FIFO depth");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench of the XY mesh router with credit flow control.
`timescale 1ns / 1ps

module tb;

    localparam int FIFO_DEPTH  = mxr_pkg::FIFO_DEPTH_DEF;
    localparam int LOCAL_DEPTH = mxr_pkg::LOCAL_DEPTH_DEF;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [7:0]   i_cfg_data;

    // Router copy: coordinates, link FIFOs, output credits and local queue.
    logic [7:0]  pos_x = 8'h00;
    logic [7:0]  pos_y = 8'h00;
    logic [15:0] lnk_store [mxr_pkg::NUM_PORTS][FIFO_DEPTH];
    int unsigned lnk_head [mxr_pkg::NUM_PORTS] = '{default: 0};
    int unsigned lnk_fill [mxr_pkg::NUM_PORTS] = '{default: 0};
    int unsigned lnk_credit [mxr_pkg::NUM_PORTS] = '{default: FIFO_DEPTH};
    logic [15:0] loc_dst [LOCAL_DEPTH];
    logic [9:0]  loc_cnt [LOCAL_DEPTH];
    int unsigned loc_head = 0;
    int unsigned loc_fill = 0;

    mxr_pkg::t_out_word expected_words [$];
    int          errors = 0;
    int          idle_pct;
    int          stall_pct;

    mesh_xy_credit_router u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // X first, then Y, otherwise the packet is for this node.
    function automatic mxr_pkg::t_port xy_direction(input logic [15:0] dst);
        if (dst[7:0] > pos_x) begin
            return mxr_pkg::PORT_RIGHT;
        end else if (dst[7:0] < pos_x) begin
            return mxr_pkg::PORT_LEFT;
        end else if (dst[15:8] > pos_y) begin
            return mxr_pkg::PORT_UP;
        end else if (dst[15:8] < pos_y) begin
            return mxr_pkg::PORT_DOWN;
        end
        return mxr_pkg::PORT_EJECT;
    endfunction

    // A head moves if its output is still free this tick and has a credit.
    function automatic bit claim_output(input logic [15:0] dst, inout logic [4:0] used,
                                        inout mxr_pkg::t_out_word res);
        mxr_pkg::t_port p;
        p = xy_direction(dst);
        if (used[p]) return 1'b0;
        if (p == mxr_pkg::PORT_EJECT) begin
            res.eject_valid = 1'b1;
            res.eject_dst   = dst;
        end else begin
            if (lnk_credit[p] == 0) return 1'b0;
            lnk_credit[p]--;
            case (p)
                mxr_pkg::PORT_LEFT:  res.send_dst_left  = dst;
                mxr_pkg::PORT_RIGHT: res.send_dst_right = dst;
                mxr_pkg::PORT_UP:    res.send_dst_up    = dst;
                default:             res.send_dst_down  = dst;
            endcase
        end
        used[p] = 1'b1;
        return 1'b1;
    endfunction

    // One accepted word: either a local load or a full arbitration tick.
    function automatic mxr_pkg::t_out_word predict_router(input logic kind,
                                                          input mxr_pkg::t_in_word w);
        mxr_pkg::t_out_word res;
        logic [4:0]  used;
        logic [3:0]  popped;
        logic        moved;
        logic        waiting;
        logic        dropped;
        int unsigned slot;
        logic [15:0] arrivals [mxr_pkg::NUM_PORTS];
        res     = '0;
        used    = '0;
        popped  = '0;
        moved   = 1'b0;
        waiting = 1'b0;
        dropped = 1'b0;
        if (kind == mxr_pkg::KIND_LOAD) begin
            if (loc_fill < LOCAL_DEPTH) begin
                slot          = (loc_head + loc_fill) % LOCAL_DEPTH;
                loc_dst[slot] = w.local_dst;
                loc_cnt[slot] = w.local_count;
                loc_fill++;
            end else begin
                res.load_rejected = 1'b1;
            end
            return res;
        end
        // Link heads in fixed priority, then the local head.
        for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
            if (lnk_fill[i] > 0) begin
                waiting = 1'b1;
                if (claim_output(lnk_store[i][lnk_head[i]], used, res)) begin
                    lnk_head[i] = (lnk_head[i] + 1) % FIFO_DEPTH;
                    lnk_fill[i]--;
                    popped[i] = 1'b1;
                    moved     = 1'b1;
                end
            end
        end
        if (loc_fill > 0) begin
            waiting = 1'b1;
            if (claim_output(loc_dst[loc_head], used, res)) begin
                if (loc_cnt[loc_head] <= 10'd1) begin
                    loc_head = (loc_head + 1) % LOCAL_DEPTH;
                    loc_fill--;
                end else begin
                    loc_cnt[loc_head]--;
                end
                moved = 1'b1;
            end
        end
        // Credits saturate at the FIFO depth.
        for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
            if (w.credit_return[i] && lnk_credit[i] < FIFO_DEPTH) lnk_credit[i]++;
        end
        // Arrivals go in after the pops of this tick.
        arrivals[0] = w.arrive_dst_left;
        arrivals[1] = w.arrive_dst_right;
        arrivals[2] = w.arrive_dst_up;
        arrivals[3] = w.arrive_dst_down;
        for (int i = 0; i < mxr_pkg::NUM_PORTS; i++) begin
            if (w.link_valid[i]) begin
                if (lnk_fill[i] < FIFO_DEPTH) begin
                    slot               = (lnk_head[i] + lnk_fill[i]) % FIFO_DEPTH;
                    lnk_store[i][slot] = arrivals[i];
                    lnk_fill[i]++;
                end else begin
                    dropped = 1'b1;
                end
            end
        end
        res.send_valid     = used[3:0];
        res.credit_release = popped;
        res.busy_res       = moved;
        res.pending        = waiting;
        res.overflow       = dropped;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic compare_word(input mxr_pkg::t_out_word exp_w,
                                input mxr_pkg::t_out_word act_w);
        check_field("send_valid", 16'(exp_w.send_valid), 16'(act_w.send_valid));
        check_field("send_dst_left", exp_w.send_dst_left, act_w.send_dst_left);
        check_field("send_dst_right", exp_w.send_dst_right, act_w.send_dst_right);
        check_field("send_dst_up", exp_w.send_dst_up, act_w.send_dst_up);
        check_field("send_dst_down", exp_w.send_dst_down, act_w.send_dst_down);
        check_field("eject_valid", 16'(exp_w.eject_valid), 16'(act_w.eject_valid));
        check_field("eject_dst", exp_w.eject_dst, act_w.eject_dst);
        check_field("credit_release", 16'(exp_w.credit_release),
                    16'(act_w.credit_release));
        check_field("busy_res", 16'(exp_w.busy_res), 16'(act_w.busy_res));
        check_field("pending", 16'(exp_w.pending), 16'(act_w.pending));
        check_field("load_rejected", 16'(exp_w.load_rejected), 16'(act_w.load_rejected));
        check_field("overflow", 16'(exp_w.overflow), 16'(act_w.overflow));
        check_field("pad", 16'(exp_w.pad), 16'(act_w.pad));
    endtask

    // Results are checked before new words are predicted within one edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $error("result word %h arrived with nothing expected", m_axis_tdata);
                    errors++;
                end else begin
                    compare_word(expected_words.pop_front(),
                                 mxr_pkg::t_out_word'(m_axis_tdata));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_words.push_back(predict_router(s_axis_tuser,
                                         mxr_pkg::t_in_word'(s_axis_tdata)));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mxr_pkg::CFG_OWN_X) begin
                    pos_x = i_cfg_data;
                end else begin
                    pos_y = i_cfg_data;
                end
            end
        end
    end

    // Offer one word after idle cycles drawn at the current rate, and wait for
    // its handshake.
    task automatic push_word(input logic kind, input mxr_pkg::t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and let every result come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_position(input logic [7:0] x, input logic [7:0] y);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= mxr_pkg::CFG_OWN_X;
        i_cfg_data  <= x;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= mxr_pkg::CFG_OWN_Y;
        i_cfg_data  <= y;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Tick word; the local fields are ignored and carry noise.
    function automatic mxr_pkg::t_in_word tick_word(input logic [3:0] lv,
                                                    input logic [15:0] l,
                                                    input logic [15:0] r,
                                                    input logic [15:0] u,
                                                    input logic [15:0] d,
                                                    input logic [3:0] cr);
        mxr_pkg::t_in_word w;
        w                  = '0;
        w.link_valid       = lv;
        w.arrive_dst_left  = l;
        w.arrive_dst_right = r;
        w.arrive_dst_up    = u;
        w.arrive_dst_down  = d;
        w.credit_return    = cr;
        w.local_dst        = 16'($urandom);
        w.local_count      = 10'($urandom);
        return w;
    endfunction

    // Load word; the link fields are ignored and carry noise.
    function automatic mxr_pkg::t_in_word load_word(input logic [15:0] dst,
                                                    input logic [9:0] cnt);
        mxr_pkg::t_in_word w;
        w             = tick_word(4'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 4'($urandom));
        w.local_dst   = dst;
        w.local_count = cnt;
        return w;
    endfunction

    // Destinations cluster around this node so that every direction is hit.
    function automatic logic [15:0] pick_dst();
        case ($urandom_range(0, 3))
            0:       return {pos_y, pos_x};
            1:       return {pos_y, 8'($urandom)};
            2:       return {8'($urandom), pos_x};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_routes();
        set_position(8'h80, 8'h80);
        idle_pct  = 0;
        stall_pct = 0;
        // Credits already full: these returns are lost.
        push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'hF));
        push_word(mxr_pkg::KIND_TICK,
                  tick_word(4'hF, 16'h0000, 16'hFFFF, 16'h8080, 16'hFF80, 4'h0));
        push_word(mxr_pkg::KIND_TICK, tick_word(4'h8, 16'h0, 16'h0, 16'h0, 16'h0080, 4'h0));
        push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0));
        push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'hF));
    endtask

    // All four links want the ejection port at once.
    task automatic test_priority();
        push_word(mxr_pkg::KIND_TICK,
                  tick_word(4'hF, 16'h8080, 16'h8080, 16'h8080, 16'h8080, 4'hF));
        repeat (4) begin
            push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'hF));
        end
    endtask

    // Use up the right-port credits until the left FIFO fills and drops.
    task automatic test_credit_limit();
        repeat (10) begin
            push_word(mxr_pkg::KIND_TICK,
                      tick_word(4'h1, 16'h80FF, 16'h0, 16'h0, 16'h0, 4'h0));
        end
        // A late credit: this arrival drops; the pop it allows frees room.
        push_word(mxr_pkg::KIND_TICK, tick_word(4'h1, 16'h80FF, 16'h0, 16'h0, 16'h0, 4'h2));
        push_word(mxr_pkg::KIND_TICK, tick_word(4'h1, 16'h80FF, 16'h0, 16'h0, 16'h0, 4'h0));
    endtask

    // A count of zero sends one copy, like a count of one.
    task automatic test_local_entries();
        push_word(mxr_pkg::KIND_LOAD, load_word(16'h8080, 10'd0));
        push_word(mxr_pkg::KIND_LOAD, load_word(16'h0000, 10'd1));
        push_word(mxr_pkg::KIND_LOAD, load_word(16'h8080, 10'd3));
        repeat (5) begin
            push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'hF));
        end
    endtask

    // Fill the local queue past its depth, then drain it.
    task automatic test_local_queue_full();
        set_position(8'h10, 8'h20);
        repeat (LOCAL_DEPTH + 2) begin
            push_word(mxr_pkg::KIND_LOAD, load_word(pick_dst(), 10'($urandom_range(1, 2))));
        end
        repeat (140) begin
            push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'($urandom), 16'($urandom),
                                                    16'($urandom), 16'($urandom), 4'hF));
        end
    endtask

    // Mostly ticks with random arrivals and credits; now and then a local load.
    task automatic test_random_traffic(input int n, input int idle, input int stall,
                                       input logic [7:0] x, input logic [7:0] y);
        set_position(x, y);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) begin
            if ($urandom_range(99) < 15) begin
                push_word(mxr_pkg::KIND_LOAD, load_word(pick_dst(), ($urandom_range(99) < 3) ?
                          10'($urandom) : 10'($urandom_range(0, 4))));
            end else begin
                push_word(mxr_pkg::KIND_TICK, tick_word(4'($urandom), pick_dst(), pick_dst(),
                                                        pick_dst(), pick_dst(),
                                                        4'($urandom)));
            end
        end
    endtask

    // The largest count ties up the local head for the rest of the run.
    task automatic test_long_entry();
        push_word(mxr_pkg::KIND_LOAD, load_word({pos_y, pos_x}, 10'h3FF));
        repeat (10) begin
            push_word(mxr_pkg::KIND_TICK, tick_word(4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'hF));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = mxr_pkg::KIND_TICK;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = mxr_pkg::CFG_OWN_X;
        i_cfg_data    = 8'h00;
        idle_pct      = 0;
        stall_pct     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_routes();
        test_priority();
        test_credit_limit();
        test_local_entries();
        test_local_queue_full();
        test_random_traffic(150, 0, 0, 8'h00, 8'h00);
        test_random_traffic(150, 69, 0, 8'hFF, 8'hFF);
        test_random_traffic(150, 0, 69, 8'($urandom), 8'($urandom));
        test_random_traffic(150, 28, 28, 8'h80, 8'h4D);
        test_long_entry();

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
